/* src/rppc_pkg.sv */
// Shared types, register codes and arithmetic helpers for the row predictive pixel coder.
// No dependencies; every other file in src imports this package.
package rppc_pkg;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 13;
   localparam logic [CSR_DATA_BITS-1:0] IMAGE_WIDTH_RESET = 13'd4096;

   // XOR with this converts an offset-binary byte to two's complement and back
   localparam logic [7:0] SIGN_FLIP = 8'h80;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DECODE_MODE = 1'b0,
      CSR_IMAGE_WIDTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       start_of_image;
      logic [7:0] in_byte_a;
      logic [7:0] in_byte_b;
      logic [7:0] in_byte_c;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte_a;
      logic [7:0] out_byte_b;
      logic [7:0] out_byte_c;
   } rsp_item_type;

   // One stored column of the previous row: Y, U-Y, V-Y
   typedef struct packed {
      logic signed [8:0] y;
      logic signed [8:0] uy;
      logic signed [8:0] vy;
   } line_entry_type;

   // Which neighbors of the current pixel lie inside the image
   typedef struct packed {
      logic nw_ok;
      logic n_ok;
      logic ne_ok;
   } nbr_ok_type;

   // (2N + NW + NE + 2) >> 2 with floor rounding
   function automatic logic signed [9:0] pred3(input logic signed [8:0] nw,
                                               input logic signed [8:0] n,
                                               input logic signed [8:0] ne);
      logic signed [11:0] sum;
      sum = (12'(n) <<< 1) + 12'(nw) + 12'(ne) + 12'sd2;
      return 10'(sum >>> 2);
   endfunction

   function automatic logic signed [7:0] clamp8(input logic signed [10:0] v);
      logic signed [7:0] res;
      if (v < -11'sd128) begin
         res = -8'sd128;
      end else if (v > 11'sd127) begin
         res = 8'sd127;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

endpackage

/* src/rppc_line_store.sv */
// Previous-row store: one write port, two registered read ports.
// Depends on rppc_pkg for the entry type.
module rppc_line_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  rppc_pkg::line_entry_type wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr_a,
   input  logic [AW-1:0]            rd_addr_b,
   output rppc_pkg::line_entry_type rd_data_a,
   output rppc_pkg::line_entry_type rd_data_b
);
   import rppc_pkg::*;

   line_entry_type mem [DEPTH];
   line_entry_type rd_a_ff;
   line_entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* src/rppc_scan_ctrl.sv */
// Raster position tracking: column counter, first-row flag, line-store addresses.
// Depends on rppc_pkg.
module rppc_scan_ctrl #(
   parameter int MAX_WIDTH = 4096,
   parameter int CW        = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               start_of_image,
   input  logic [rppc_pkg::CSR_DATA_BITS-1:0] image_width,
   output logic [CW-1:0]                      addr_n,
   output logic [CW-1:0]                      addr_ne,
   output rppc_pkg::nbr_ok_type               nbr_ok
);
   import rppc_pkg::*;

   localparam int WB = (CW + 1 > CSR_DATA_BITS) ? CW + 1 : CSR_DATA_BITS;

   logic [CW-1:0] column_ff, column_in;
   logic          first_row_ff, first_row_in;

   logic [WB-1:0] width_ext, max_ext, eff_width, c_plus;
   logic [CW-1:0] col;
   logic          row_first, wrap;

   assign width_ext = WB'(image_width);
   assign max_ext   = WB'(MAX_WIDTH);

   always_comb begin
      // zero acts as one, oversize acts as the store depth
      if (width_ext == '0) begin
         eff_width = WB'(1);
      end else if (width_ext > max_ext) begin
         eff_width = max_ext;
      end else begin
         eff_width = width_ext;
      end
   end

   always_comb begin
      priority if (start_of_image) begin
         col       = '0;
         row_first = 1'b1;
      end else if (WB'(column_ff) >= eff_width) begin
         // width shrunk mid-row: begin a new row
         col       = '0;
         row_first = 1'b0;
      end else begin
         col       = column_ff;
         row_first = first_row_ff;
      end
   end

   assign c_plus = WB'(col) + WB'(1);
   assign wrap   = (c_plus >= eff_width);

   assign column_in    = wrap ? '0 : c_plus[CW-1:0];
   assign first_row_in = wrap ? 1'b0 : row_first;

   assign addr_n       = col;
   assign addr_ne      = c_plus[CW-1:0];
   assign nbr_ok.n_ok  = !row_first;
   assign nbr_ok.nw_ok = !row_first && (col != '0);
   assign nbr_ok.ne_ok = !row_first && !wrap;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         first_row_ff <= 1'b1;
      end else if (accept) begin
         column_ff    <= column_in;
         first_row_ff <= first_row_in;
      end
   end

endmodule

/* src/rppc_pixel_math.sv */
// Per-pixel prediction, clamping and residual / reconstruction arithmetic.
// Purely combinational; depends on rppc_pkg.
module rppc_pixel_math (
   input  logic                     decode_mode,
   input  rppc_pkg::req_item_type   item,
   input  rppc_pkg::line_entry_type nw,
   input  rppc_pkg::line_entry_type n,
   input  rppc_pkg::line_entry_type ne,
   output rppc_pkg::rsp_item_type   result,
   output rppc_pkg::line_entry_type cur
);
   import rppc_pkg::*;

   logic signed [9:0] yp, up, vp;
   logic signed [7:0] y, u, v;
   logic signed [7:0] up_c, vp_c;

   assign yp = pred3(nw.y,  n.y,  ne.y);
   assign up = pred3(nw.uy, n.uy, ne.uy);
   assign vp = pred3(nw.vy, n.vy, ne.vy);

   // decode: Y wraps to 8 bits after adding its prediction
   assign y = decode_mode ? 8'(item.in_byte_a + yp[7:0]) : 8'(item.in_byte_b ^ SIGN_FLIP);

   // chroma prediction is relative to this pixel's Y
   assign up_c = clamp8(11'(up) + 11'(y));
   assign vp_c = clamp8(11'(vp) + 11'(y));

   assign u = decode_mode ? 8'(item.in_byte_b + up_c) : 8'(item.in_byte_c ^ SIGN_FLIP);
   assign v = decode_mode ? 8'(item.in_byte_c + vp_c) : 8'(item.in_byte_a ^ SIGN_FLIP);

   always_comb begin
      if (decode_mode) begin
         result.out_byte_a = v ^ SIGN_FLIP;
         result.out_byte_b = y ^ SIGN_FLIP;
         result.out_byte_c = u ^ SIGN_FLIP;
      end else begin
         result.out_byte_a = 8'(y - yp[7:0]);
         result.out_byte_b = 8'(u - up_c);
         result.out_byte_c = 8'(v - vp_c);
      end
   end

   assign cur.y  = 9'(y);
   assign cur.uy = 9'(u) - 9'(y);
   assign cur.vy = 9'(v) - 9'(y);

endmodule

/* src/row_predictive_pixel_coder.sv */
// Row predictive pixel coder, top level: config registers, pipeline and output register.
// Stage 1 registers an accepted item during the line-store read; the output register takes
//   the computed result. Throughput: one item per cycle unless rsp_stall holds the output;
//   the line store's two read ports and one write port set it.
// Reset (synchronous): clears valids, scan state, decode_mode=0, width=4096; line store kept.
// Depends on rppc_pkg, rppc_scan_ctrl, rppc_line_store and rppc_pixel_math.
module row_predictive_pixel_coder #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel / residual items in
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rppc_pkg::req_item_type              req_data,
   // result items out
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rppc_pkg::rsp_item_type              rsp_data,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rppc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rppc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import rppc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   // ---------------- configuration registers ----------------
   logic                     decode_mode_ff;
   logic [CSR_DATA_BITS-1:0] image_width_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 1'b0;
         image_width_ff <= IMAGE_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_DECODE_MODE: decode_mode_ff <= csr_wdata[0];
            CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- handshake ----------------
   // Stage 1 holds the item whose line-store data is arriving; it moves into the
   // output register whenever that register is empty or being drained.
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic out_free, s1_move, accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // ---------------- scan position ----------------
   logic [CW-1:0] addr_n, addr_ne;
   nbr_ok_type    nbr_ok;

   rppc_scan_ctrl #(
      .MAX_WIDTH(MAX_WIDTH),
      .CW       (CW)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .start_of_image(req_data.start_of_image),
      .image_width   (image_width_ff),
      .addr_n        (addr_n),
      .addr_ne       (addr_ne),
      .nbr_ok        (nbr_ok)
   );

   // ---------------- line store ----------------
   // Read at accept time for N and NE; stage 1 writes its own column back.
   logic           wr_en;
   line_entry_type wr_data;
   line_entry_type rd_n, rd_ne;
   logic [CW-1:0]  s1_col_ff;

   assign wr_en = s1_move;

   rppc_line_store #(
      .DEPTH(MAX_WIDTH),
      .AW   (CW)
   ) u_line (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (s1_col_ff),
      .wr_data  (wr_data),
      .rd_en    (accept),
      .rd_addr_a(addr_n),
      .rd_addr_b(addr_ne),
      .rd_data_a(rd_n),
      .rd_data_b(rd_ne)
   );

   // ---------------- stage 1 registers ----------------
   // A write in the same edge as a read is not seen by the memory: that only
   // happens when a row or image restarts at column 0 right after column 0 or 1,
   // and the written entry is forwarded instead.
   req_item_type   s1_item_ff;
   nbr_ok_type     s1_nbr_ff;
   logic           s1_fwd_n_ff, s1_fwd_ne_ff;
   line_entry_type fwd_data_ff;
   line_entry_type prev_n_ff;      // N of the previous pixel = NW of this one
   logic           fwd_n_in, fwd_ne_in;

   assign fwd_n_in  = s1_move && (s1_col_ff == addr_n);
   assign fwd_ne_in = s1_move && (s1_col_ff == addr_ne);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff   <= req_data;
         s1_col_ff    <= addr_n;
         s1_nbr_ff    <= nbr_ok;
         s1_fwd_n_ff  <= fwd_n_in;
         s1_fwd_ne_ff <= fwd_ne_in;
         fwd_data_ff  <= wr_data;
      end
   end

   // ---------------- neighbor selection and pixel arithmetic ----------------
   line_entry_type n_eff, ne_eff, nw_eff;
   rsp_item_type   result;

   always_comb begin
      n_eff  = '0;
      ne_eff = '0;
      nw_eff = '0;
      if (s1_nbr_ff.n_ok) begin
         n_eff = s1_fwd_n_ff ? fwd_data_ff : rd_n;
      end
      if (s1_nbr_ff.ne_ok) begin
         ne_eff = s1_fwd_ne_ff ? fwd_data_ff : rd_ne;
      end
      if (s1_nbr_ff.nw_ok) begin
         nw_eff = prev_n_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         prev_n_ff <= n_eff;
      end
   end

   rppc_pixel_math u_math (
      .decode_mode(decode_mode_ff),
      .item       (s1_item_ff),
      .nw         (nw_eff),
      .n          (n_eff),
      .ne         (ne_eff),
      .result     (result),
      .cur        (wr_data)
   );

   // ---------------- output register ----------------
   rsp_item_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   // an accepted item always lands in stage 1
   a_accept_to_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item did not reach stage 1");

   // a new result only appears after stage 1 held an item
   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("result appeared without a stage 1 item");

   // a full pipeline behind a stalled output pushes back on the input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid && rsp_stall) |-> req_stall)
      else $error("input not stalled while pipeline is full");

endmodule

/* tb/sv/rppc_result_checker.sv */
// Result checker for the row predictive pixel coder: watches the item, result and register
// channels, predicts every result from its own copy of the coder state and compares it.
// Depends on rppc_pkg for the channel and register types.
module rppc_result_checker #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  rppc_pkg::req_item_type              req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  rppc_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [rppc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rppc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  outstanding,
   output int                                  checked_count,
   output int                                  fail_count
);
   import rppc_pkg::*;

   // one column of the previous row: Y, U-Y, V-Y
   typedef struct packed {
      logic signed [8:0] y;
      logic signed [8:0] uy;
      logic signed [8:0] vy;
   } column_sample_type;

   column_sample_type        prev_row [MAX_WIDTH];
   column_sample_type        nbr_above_left;
   column_sample_type        nbr_above;
   int unsigned              column;
   logic                     on_first_row;
   logic                     decode_on;
   logic [CSR_DATA_BITS-1:0] width_setting;
   rsp_item_type             coded_fifo [$];
   rsp_item_type             want;

   // (2N + NW + NE + 2) >> 2, floor
   function automatic int smooth3(int nw, int n, int ne);
      return (2 * n + nw + ne + 2) >>> 2;
   endfunction

   function automatic int saturate8(int v);
      return v < -128 ? -128 : (v > 127 ? 127 : v);
   endfunction

   function automatic int fold8(int v);
      logic signed [7:0] low;
      low = v[7:0];
      return low;
   endfunction

   task automatic code_pixel(input req_item_type item, output rsp_item_type res);
      int unsigned       lim;
      int unsigned       c;
      column_sample_type nw, n, ne, cur;
      int                yp, up, vp, y, u, v;
      lim = 32'(width_setting);
      if (lim < 1) lim = 1;
      if (lim > MAX_WIDTH) lim = MAX_WIDTH;
      if (item.start_of_image) begin
         column         = 0;
         on_first_row   = 1'b1;
         nbr_above_left = '0;
         nbr_above      = '0;
      end else if (column >= lim) begin
         // width shrunk under the current column
         column       = 0;
         on_first_row = 1'b0;
      end
      c  = column;
      nw = (c == 0 || on_first_row) ? '0 : nbr_above_left;
      n  = on_first_row ? '0 : prev_row[c];
      ne = (on_first_row || c + 1 >= lim) ? '0 : prev_row[c + 1];
      nbr_above = n;
      yp = smooth3(nw.y, n.y, ne.y);
      up = smooth3(nw.uy, n.uy, ne.uy);
      vp = smooth3(nw.vy, n.vy, ne.vy);
      if (decode_on) begin
         y  = fold8(int'(item.in_byte_a) + yp);
         up = saturate8(up + y);
         vp = saturate8(vp + y);
         u  = fold8(int'(item.in_byte_b) + up);
         v  = fold8(int'(item.in_byte_c) + vp);
         res.out_byte_a = 8'(v + 128);
         res.out_byte_b = 8'(y + 128);
         res.out_byte_c = 8'(u + 128);
      end else begin
         v  = int'(item.in_byte_a) - 128;
         y  = int'(item.in_byte_b) - 128;
         u  = int'(item.in_byte_c) - 128;
         up = saturate8(up + y);
         vp = saturate8(vp + y);
         res.out_byte_a = 8'(y - yp);
         res.out_byte_b = 8'(u - up);
         res.out_byte_c = 8'(v - vp);
      end
      cur.y          = 9'(y);
      cur.uy         = 9'(u - y);
      cur.vy         = 9'(v - y);
      nbr_above_left = nbr_above;
      prev_row[c]    = cur;
      column         = c + 1;
      if (column >= lim) begin
         column       = 0;
         on_first_row = 1'b0;
      end
   endtask

   task automatic flag_mismatch(input string what);
      fail_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic check_byte(input string field, input logic [7:0] got,
                             input logic [7:0] exp_byte);
      if (got !== exp_byte)
         flag_mismatch($sformatf("result %0d %s got %02h, predicted %02h",
                                 checked_count, field, got, exp_byte));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         column         = 0;
         on_first_row   = 1'b1;
         nbr_above_left = '0;
         nbr_above      = '0;
         decode_on      = 1'b0;
         width_setting  = IMAGE_WIDTH_RESET;
         coded_fifo.delete();
      end else begin
         // results first, so a same-edge item never pairs with an earlier result
         if (rsp_valid && !rsp_stall) begin
            if (coded_fifo.size() == 0) begin
               flag_mismatch("result arrived with no item waiting for it");
            end else begin
               want = coded_fifo.pop_front();
               check_byte("out_byte_a", rsp_data.out_byte_a, want.out_byte_a);
               check_byte("out_byte_b", rsp_data.out_byte_b, want.out_byte_b);
               check_byte("out_byte_c", rsp_data.out_byte_c, want.out_byte_c);
            end
            checked_count++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_DECODE_MODE: decode_on = csr_wdata[0];
               CSR_IMAGE_WIDTH: width_setting = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            code_pixel(req_data, want);
            coded_fifo.push_back(want);
         end
      end
      outstanding <= coded_fifo.size();
   end

endmodule

/* tb/sv/row_predictive_pixel_coder_tb.sv */
// Testbench top for the row predictive pixel coder: clock, reset, item and register
// stimulus, receiver stalls and the verdict. Depends on rppc_pkg, the coder RTL and
// rppc_result_checker, which does all prediction and comparison.
module row_predictive_pixel_coder_tb;
   import rppc_pkg::*;

   localparam int MAX_WIDTH    = 4096;
   localparam int RANDOM_ITEMS = 1750;
   localparam int LONG_HOLD    = 300;   // cycles the receiver refuses results once
   localparam int HOLD_AFTER   = 700;   // item count at which that hold-off starts

   typedef enum int {
      UNIFORM_BYTES,
      CORNER_BYTES,
      SMOOTH_BYTES
   } byte_style_t;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_item_type              req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_item_type              rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int outstanding, checked_count, fail_count;

   // run bookkeeping, also used for the summary
   int   items_sent    = 0;
   int   encoded_items = 0;
   int   decoded_items = 0;
   int   image_starts  = 0;
   int   settings_used = 1;   // reset settings count as the first
   logic decode_now    = 1'b0;
   int   cur_span      = MAX_WIDTH;

   // idling control
   logic sender_calm   = 1'b0;
   logic receiver_calm = 1'b0;
   logic long_hold     = 1'b0;
   int   stall_left    = 0;

   logic [7:0] last_a = '0, last_b = '0, last_c = '0;

   row_predictive_pixel_coder #(.MAX_WIDTH(MAX_WIDTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rppc_result_checker #(.MAX_WIDTH(MAX_WIDTH)) result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .outstanding   (outstanding),
      .checked_count (checked_count),
      .fail_count    (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Width the block really uses: 0 acts as 1, anything past MAX_WIDTH as MAX_WIDTH.
   function automatic int span_of(logic [CSR_DATA_BITS-1:0] width);
      if (width == 0) return 1;
      if (width > MAX_WIDTH) return MAX_WIDTH;
      return width;
   endfunction

   // Byte source per phase: uniform noise, corner values (drive the clamps and
   // the wrap), or a slow walk so predictions land close to the pixel.
   function automatic logic [7:0] pick_byte(byte_style_t style, logic [7:0] last);
      logic [7:0] corners [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
      case (style)
         CORNER_BYTES: return corners[$urandom_range(0, 5)];
         SMOOTH_BYTES: return last + 8'($urandom_range(0, 6)) - 8'd3;
         default:      return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one item after a random gap and hold it until the block takes it.
   // Returns at the edge of acceptance; valid stays high so the next item can
   // follow back to back.
   task automatic send_item(input logic sos, input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{start_of_image: sos, in_byte_a: a, in_byte_b: b, in_byte_c: c};
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (decode_now) decoded_items++;
      else encoded_items++;
      if (sos) image_starts++;
   endtask

   // Drop valid and wait until every item has come back, then let the clock run on
   // past the pipeline's stage 1 and output register so the block is surely idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // Both registers in one burst; valid stays high across the two writes.
   task automatic write_config(input logic mode, input logic [CSR_DATA_BITS-1:0] width);
      csr_valid <= 1'b1;
      csr_index <= CSR_DECODE_MODE;
      csr_wdata <= CSR_DATA_BITS'(mode);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= width;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      decode_now  = mode;
      cur_span    = span_of(width);
      settings_used++;
   endtask

   // Receiver: after each result draws a random stall length, with calm
   // stretches where it takes everything. The long hold-off overrides it.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
         stall_left = receiver_calm ? 0 : $urandom_range(0, 14);
      end else if (stall_left != 0) begin
         stall_left--;
      end
      rsp_stall <= long_hold || (stall_left != 0);
   end

   // One long hold-off in the middle of the random part: the sender keeps
   // offering, so the pipeline fills and req_stall has to come up.
   initial begin
      wait (items_sent >= HOLD_AFTER);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      long_hold <= 1'b0;
   end

   // Watchdog; worst case is far below this.
   initial begin
      #4_000_000;
      $display("timeout: %0d items sent, %0d results still owed", items_sent, outstanding);
      $display("status: fail");
      $finish;
   end

   initial begin
      int                       pick;
      int                       span;
      int                       count;
      int                       random_goal;
      logic                     mode;
      logic                     fresh;
      logic [CSR_DATA_BITS-1:0] width;
      byte_style_t              style;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // Reset settings (encode, width 4096) and no start flag: the stream must
      // behave as if an image had just begun. Row entries here are built so the
      // next row sees U-Y and V-Y at +-255 and the U/V clamps hit both ends.
      send_item(1'b0, 8'd255, 8'd0,   8'd255);
      send_item(1'b0, 8'd0,   8'd255, 8'd0);
      send_item(1'b0, 8'd0,   8'd0,   8'd0);
      send_item(1'b0, 8'd255, 8'd255, 8'd255);

      // Shrink to 2 without a start: the column is past the new width, so a
      // new row begins and predicts from the first two columns above.
      wait_idle();
      write_config(1'b0, 13'd2);
      send_item(1'b0, 8'd255, 8'd255, 8'd255);
      send_item(1'b0, 8'd0,   8'd0,   8'd0);
      send_item(1'b0, 8'd0,   8'd255, 8'd0);
      send_item(1'b0, 8'd255, 8'd0,   8'd255);
      send_item(1'b1, 8'd128, 8'd128, 8'd128);   // restart at the start of a row
      send_item(1'b0, 8'd127, 8'd127, 8'd127);

      // Decode at width 1: every pixel its own row, only N is ever used.
      wait_idle();
      write_config(1'b1, 13'd1);
      send_item(1'b1, 8'd0,   8'd0,   8'd0);
      send_item(1'b0, 8'd255, 8'd255, 8'd255);
      send_item(1'b0, 8'd128, 8'd128, 8'd128);
      send_item(1'b0, 8'd127, 8'd0,   8'd255);

      // Width 0 acts as 1, so no restart is needed.
      wait_idle();
      write_config(1'b1, 13'd0);
      send_item(1'b0, 8'd255, 8'd0,   8'd128);
      send_item(1'b0, 8'd0,   8'd255, 8'd127);

      // All-ones width acts as the maximum; growing needs a fresh image.
      wait_idle();
      write_config(1'b0, 13'd8191);
      send_item(1'b1, 8'd255, 8'd255, 8'd255);
      send_item(1'b0, 8'd0,   8'd0,   8'd0);
      send_item(1'b0, 8'd1,   8'd254, 8'd128);

      // --- random part: phases of whole images with random settings ---
      random_goal = items_sent + RANDOM_ITEMS;
      while (items_sent < random_goal) begin
         mode = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            width = 13'd0;
         end else if (pick < 10) begin
            width = 13'd1;
         end else if (pick < 14) begin
            case ($urandom_range(0, 2))
               0:       width = 13'd4096;
               1:       width = 13'd4097;
               default: width = 13'd8191;
            endcase
         end else if (pick < 24) begin
            width = 13'($urandom_range(13, 64));
         end else begin
            width = 13'($urandom_range(2, 12));
         end
         span = span_of(width);

         // Small widths get several full rows; huge ones only a short first row.
         if (span > 64) begin
            count = $urandom_range(10, 50);
         end else begin
            count = span * $urandom_range(2, 5) + $urandom_range(0, span - 1);
            if (count > 150) count = 150;
         end

         // A wider row than before would read columns never written in this
         // image, so growth always opens a new image; otherwise mostly.
         fresh       = (span > cur_span) || ($urandom_range(0, 9) < 7);
         style       = byte_style_t'($urandom_range(0, 2));
         sender_calm = ($urandom_range(0, 3) == 0);

         wait_idle();
         write_config(mode, width);
         for (int i = 0; i < count; i++) begin
            last_a = pick_byte(style, last_a);
            last_b = pick_byte(style, last_b);
            last_c = pick_byte(style, last_c);
            // rare start flags mid-image break rows at random columns
            send_item(i == 0 ? fresh : ($urandom_range(0, 49) == 0), last_a, last_b, last_c);
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("summary: %0d items over %0d register settings (%0d encoded, %0d decoded)",
               items_sent, settings_used, encoded_items, decoded_items);
      $display("summary: %0d image starts, %0d results compared, %0d mismatches",
               image_starts, checked_count, fail_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
